// File: hdl/mmu_pkg.sv
// -----------------------------------------------------------------------------
// mmu_pkg
// Types and constants shared by the paged MMU front end, back end and top.
// -----------------------------------------------------------------------------
package mmu_pkg;

    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = 1;

    localparam logic [21:0] STATUS_ZERO_PHYS_ADDR = 22'd4194170;
    localparam logic [15:0] PDR_RD_MASK = 16'o077716;
    localparam logic [15:0] PDR_WR_MASK = 16'o077416;
    localparam logic [15:0] PAR_RD_MASK = 16'o007777;
    localparam logic [17:0] ADDR18_MASK = 18'o777777;
    localparam logic [12:0] DF_MASK     = 13'o17777;
    localparam logic [21:0] IOPAGE_BASE = 22'(8'o77) << 16;

    localparam logic [2:0] MODE_REG_RD = 3'd0;
    localparam logic [2:0] MODE_REG_WR = 3'd1;
    localparam logic [2:0] MODE_TBL_RD = 3'd2;
    localparam logic [2:0] MODE_TBL_WR = 3'd3;
    localparam logic [2:0] MODE_XLATE  = 3'd4;
    localparam logic [2:0] MODE_RESET  = 3'd5;
    localparam logic [2:0] MODE_NOP    = 3'd7;

    localparam logic [1:0] OC_OK    = 2'd0;
    localparam logic [1:0] OC_ABORT = 2'd1;
    localparam logic [1:0] OC_TRAP  = 2'd2;

    localparam logic [1:0] CM_KERNEL = 2'd0;
    localparam logic [1:0] CM_SUPER  = 2'd1;
    localparam logic [1:0] CM_USER   = 2'd3;

    localparam logic [1:0] REG_SR0 = 2'd0;
    localparam logic [1:0] REG_SR1 = 2'd1;
    localparam logic [1:0] REG_SR2 = 2'd2;
    localparam logic [1:0] REG_SR3 = 2'd3;

    // PDR access control field
    localparam logic [2:0] ACF_NONRES  = 3'd0;
    localparam logic [2:0] ACF_RO_TRAP = 3'd1;
    localparam logic [2:0] ACF_RO      = 3'd2;
    localparam logic [2:0] ACF_RSVD3   = 3'd3;
    localparam logic [2:0] ACF_TRAP_RW = 3'd4;
    localparam logic [2:0] ACF_TRAP_WR = 3'd5;
    localparam logic [2:0] ACF_RW      = 3'd6;
    localparam logic [2:0] ACF_RSVD7   = 3'd7;

    typedef struct packed {
        logic [2:0]  mode;
        logic [1:0]  processor_mode;
        logic        is_fetch;
        logic        is_write;
        logic        in_trap;
        logic        wbit_inhibit;
        logic [15:0] virtual_address;
        logic [1:0]  table_select;
        logic [5:0]  io_offset;
        logic [1:0]  reg_select;
        logic [15:0] write_data;
        logic        byte_write;
    } t_in;

    typedef struct packed {
        logic [15:0] read_data;
        logic [21:0] physical_address;
        logic [1:0]  outcome;
    } t_out;

    // classified item handed from front to back
    typedef struct packed {
        logic [2:0]  mode;
        logic [5:0]  idx;
        logic        sel_par;
        logic        odd_byte;
        logic        byte_write;
        logic [15:0] write_data;
        logic [1:0]  reg_select;
        logic [1:0]  cm;
        logic        is_fetch;
        logic        is_write;
        logic        no_wbit;
        logic        in_trap;
        logic [15:0] va;
    } t_op;

    function automatic logic [15:0] merge_byte(logic [15:0] old, logic [15:0] d,
                                               logic odd);
        return odd ? {d[7:0], old[7:0]} : {old[15:8], d[7:0]};
    endfunction

endpackage

// File: hdl/paged_mmu_translate_and_check.sv
// -----------------------------------------------------------------------------
// paged_mmu_translate_and_check
// Paged MMU: status and page table access plus virtual address translation.
// -----------------------------------------------------------------------------
// Each item first reads the PAR/PDR pair from the synchronous table RAM in the
// back end, then executes and writes back any table update.
// A two-entry queue in front accepts items while the back end is busy, and
// the result register holds one result for pop. After reset the block sweeps
// the 64-entry tables to zero before the first item executes.
module paged_mmu_translate_and_check import mmu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_in  i_item,
    output logic empty,
    input  logic pop,
    output t_out o_result
);

    logic w_op_valid, w_op_take;
    t_op  w_op;

    mmu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_item     (i_item),
        .o_op_valid (w_op_valid),
        .o_op       (w_op),
        .i_op_take  (w_op_take)
    );

    mmu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (w_op_valid),
        .i_op       (w_op),
        .o_op_take  (w_op_take),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_res      (o_result)
    );

endmodule

// File: hdl/mmu_front.sv
// -----------------------------------------------------------------------------
// mmu_front
// Accepts items, forms the table index and fields, and queues them for the
// back end.
// -----------------------------------------------------------------------------
module mmu_front import mmu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_full,
    input  t_in  i_item,
    output logic o_op_valid,
    output t_op  o_op,
    input  logic i_op_take
);

    t_op              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_cnt;
    t_op               w_op;
    logic              w_push, w_pop;

    always_comb begin
        w_op            = '0;
        w_op.mode       = i_item.mode;
        w_op.idx        = {i_item.table_select, i_item.io_offset[4:1]};
        w_op.sel_par    = i_item.io_offset[5];
        w_op.odd_byte   = i_item.io_offset[0];
        w_op.byte_write = i_item.byte_write;
        w_op.write_data = i_item.write_data;
        w_op.reg_select = i_item.reg_select;
        w_op.cm         = i_item.processor_mode;
        w_op.is_fetch   = i_item.is_fetch;
        w_op.is_write   = i_item.is_write;
        w_op.no_wbit    = i_item.wbit_inhibit;
        w_op.in_trap    = i_item.in_trap;
        w_op.va         = i_item.virtual_address;
    end

    assign o_full     = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign w_push     = i_push && !o_full;
    assign o_op_valid = (r_cnt != '0);
    assign w_pop      = i_op_take && o_op_valid;
    assign o_op       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_op;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QPTR_W+1)'(w_push) - (QPTR_W+1)'(w_pop);
        end
    end

endmodule

// File: hdl/mmu_back.sv
// -----------------------------------------------------------------------------
// mmu_back
// Executes register, table, translate and reset items. Table words live in
// synchronous RAM; a translate reads the entry, then may write back the PDR.
// -----------------------------------------------------------------------------
module mmu_back import mmu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_op_valid,
    input  t_op  i_op,
    output logic o_op_take,
    output logic o_empty,
    input  logic i_pop,
    output t_out o_res
);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_CLEAR} t_state;

    t_state      r_state;
    logic [15:0] r_par [64];
    logic [15:0] r_pdr [64];
    logic [15:0] r_par_q, r_pdr_q;
    logic [15:0] r_sr0, r_sr2, r_sr3;
    logic [5:0]  r_clr;
    t_op         r_op;
    t_out        r_res;
    logic        r_full;

    logic [5:0]  w_raddr;
    logic        w_ds, w_take;
    logic [5:0]  w_xidx;
    t_op         w_op_in;

    // translate fields
    logic [15:0] w_pdrv, w_parv;
    logic [17:0] w_adder;
    logic [21:0] w_mpa;
    logic [6:0]  w_bn, w_plf;
    logic        w_ple;
    logic        upd, set_a, set_w, f_nr, f_ple, f_ro, f_pg, ab, tr;
    logic        w_pdr_we, w_par_we;
    logic [5:0]  w_waddr;
    logic [15:0] w_pdr_wd, w_par_wd, n_sr0, n_sr2, n_sr3;
    t_out        n_res;
    logic [2:0]  w_apf;

    assign o_empty = !r_full;
    assign o_res   = r_res;
    // take a new op when idle and the result slot is free or being drained
    assign w_take    = (r_state == S_IDLE) && i_op_valid && (!r_full || i_pop);
    assign o_op_take = w_take;

    always_comb begin
        unique case (i_op.cm)
            CM_KERNEL: w_ds = r_sr3[2];
            CM_SUPER:  w_ds = r_sr3[1];
            CM_USER:   w_ds = r_sr3[0];
            default:   w_ds = 1'b0;
        endcase
        w_xidx = {(i_op.in_trap ? CM_KERNEL : i_op.cm), (w_ds && !i_op.is_fetch),
                  i_op.va[15:13]};
        w_raddr = (i_op.mode == MODE_XLATE) ? w_xidx : i_op.idx;
        w_op_in     = i_op;
        w_op_in.idx = w_raddr;
    end

    always_comb begin
        w_apf   = r_op.va[15:13];
        w_pdrv  = r_pdr_q & PDR_RD_MASK;
        w_parv  = r_par_q & PAR_RD_MASK;
        w_adder = (18'(w_parv) << 6) + 18'(r_op.va[12:0] & DF_MASK);
        w_adder = w_adder & ADDR18_MASK;
        w_mpa   = (w_adder[17:13] == 5'b11111) ? (IOPAGE_BASE | 22'(w_adder[15:0]))
                                               : 22'(w_adder);
        w_bn    = r_op.va[12:6];
        w_plf   = w_pdrv[14:8];
        w_ple   = w_pdrv[3] ? (w_bn < w_plf) : (w_bn > w_plf);
        upd = 1'b0; set_a = 1'b0; set_w = 1'b0; f_nr = 1'b0; f_ple = 1'b0;
        f_ro = 1'b0; f_pg = 1'b0; ab = 1'b0; tr = 1'b0;
        if (r_op.is_write) begin
            case (w_pdrv[2:0]) inside
                ACF_NONRES, ACF_RSVD3, ACF_RSVD7: begin
                    upd = 1'b1; f_pg = 1'b1; f_nr = 1'b1; f_ple = w_ple; ab = 1'b1;
                end
                ACF_RO_TRAP, ACF_RO: begin
                    upd = 1'b1; f_pg = 1'b1; f_ro = 1'b1; f_ple = w_ple; ab = 1'b1;
                end
                ACF_TRAP_RW: begin
                    upd = 1'b1; set_a = 1'b1; f_nr = 1'b1; f_pg = 1'b1; tr = 1'b1;
                end
                ACF_RW: begin
                    upd = 1'b1; f_pg = 1'b1;
                    set_w = !r_op.no_wbit && (w_mpa != STATUS_ZERO_PHYS_ADDR);
                    f_ple = w_ple; tr = w_ple;
                end
                default: ;
            endcase
        end else begin
            case (w_pdrv[2:0]) inside
                ACF_NONRES, ACF_RSVD3, ACF_RSVD7: begin
                    f_nr = 1'b1; f_pg = 1'b1; f_ple = w_ple; ab = 1'b1;
                end
                ACF_TRAP_RW: begin
                    upd = 1'b1; set_a = 1'b1; f_ple = w_ple; f_pg = 1'b1;
                    f_nr = 1'b1; tr = 1'b1;
                end
                ACF_RO, ACF_TRAP_WR, ACF_RW: begin
                    f_pg = 1'b1; f_ple = w_ple; ab = w_ple;
                end
                default: ;
            endcase
        end
    end

    // result and state updates for the op held in r_op (S_EXEC)
    always_comb begin
        n_res = '0;
        n_sr0 = r_sr0; n_sr2 = r_sr2; n_sr3 = r_sr3;
        w_pdr_we = 1'b0; w_par_we = 1'b0;
        w_waddr = r_op.idx; w_pdr_wd = '0; w_par_wd = '0;
        unique case (r_op.mode)
            MODE_REG_RD: begin
                case (r_op.reg_select)
                    REG_SR0: n_res.read_data = r_sr0;
                    REG_SR2: n_res.read_data = r_sr2;
                    REG_SR3: n_res.read_data = r_sr3;
                    default: n_res.read_data = '0;
                endcase
            end
            MODE_REG_WR: begin
                if (r_op.reg_select == REG_SR0)
                    n_sr0 = r_op.byte_write ? merge_byte(r_sr0, r_op.write_data, 1'b0)
                                            : r_op.write_data;
                else if (r_op.reg_select == REG_SR3)
                    n_sr3 = r_op.byte_write ? merge_byte(r_sr3, r_op.write_data, 1'b0)
                                            : r_op.write_data;
            end
            MODE_TBL_RD: begin
                n_res.read_data = r_op.sel_par ? (r_par_q & PAR_RD_MASK)
                                               : (r_pdr_q & PDR_RD_MASK);
            end
            MODE_TBL_WR: begin
                if (r_op.sel_par) begin
                    w_par_we = 1'b1;
                    w_par_wd = r_op.byte_write ?
                        merge_byte(r_par_q, r_op.write_data, r_op.odd_byte) : r_op.write_data;
                end else begin
                    w_pdr_we = 1'b1;
                    w_pdr_wd = (r_op.byte_write ?
                        merge_byte(r_pdr_q, r_op.write_data, r_op.odd_byte) : r_op.write_data)
                        & PDR_WR_MASK;
                end
            end
            MODE_XLATE: begin
                if (r_op.is_fetch && !((r_sr0[15:13] != 3'b000) || r_op.cm == CM_SUPER))
                    n_sr2 = r_op.va;
                if (!r_sr0[0]) begin
                    n_res.physical_address = 22'(r_op.va);
                end else begin
                    w_waddr  = r_op.idx;
                    w_pdr_we = upd;
                    w_pdr_wd = w_pdrv | (set_a ? 16'o200 : 16'o0) | (set_w ? 16'o100 : 16'o0);
                    if ((f_nr || f_ple || f_ro || f_pg) && r_sr0[15:13] == 3'b000) begin
                        n_sr0[15] = f_nr | r_sr0[15];
                        n_sr0[14] = f_ple | r_sr0[14];
                        n_sr0[13] = f_ro | r_sr0[13];
                        if (f_pg) begin
                            n_sr0[6:5] = r_op.cm;
                            n_sr0[3:1] = w_apf;
                        end
                    end
                    if (ab)      n_res.outcome = OC_ABORT;
                    else if (tr) n_res.outcome = OC_TRAP;
                    else         n_res.physical_address = w_mpa;
                end
            end
            MODE_RESET: begin
                n_sr0 = r_sr0 & ~16'o160400;
            end
            default: ;
        endcase
    end

    // tables: one read port (registered), one write port; clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            r_par[r_clr] <= '0;
            r_pdr[r_clr] <= '0;
        end else if (r_state == S_EXEC) begin
            if (w_par_we) r_par[w_waddr] <= w_par_wd;
            if (w_pdr_we) r_pdr[w_waddr] <= w_pdr_wd;
        end
        r_par_q <= r_par[w_raddr];
        r_pdr_q <= r_pdr[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_op <= w_op_in;
        end
        if (r_state == S_EXEC) r_res <= n_res;
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_full  <= 1'b0;
            r_sr0   <= '0;
            r_sr2   <= '0;
            r_sr3   <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == 6'd63) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_pop) r_full <= 1'b0;
                    if (w_take) r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_sr0   <= n_sr0;
                    r_sr2   <= n_sr2;
                    r_sr3   <= n_sr3;
                    r_full  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: hdl/mmu_checker.sv
// -----------------------------------------------------------------------------
// mmu_checker
// Port-level checks for the paged MMU.
// -----------------------------------------------------------------------------
module mmu_checker import mmu_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic full,
    input logic empty,
    input logic pop,
    input t_out o_result
);

    a_outcome_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.outcome == OC_OK || o_result.outcome == OC_ABORT ||
                    o_result.outcome == OC_TRAP)) else $error("bad outcome code");

    a_fail_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.outcome != OC_OK) |-> o_result.physical_address == '0)
        else $error("address on fault");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result))) else $error("result lost");

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (empty && !full)) else $error("not idle after reset");

endmodule

bind paged_mmu_translate_and_check mmu_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .full(full),
    .empty(empty), .pop(pop), .o_result(o_result)
);

// File: tb/sv/tb_paged_mmu_translate_and_check.sv
// -----------------------------------------------------------------------------
// tb_paged_mmu_translate_and_check
// Self-checking bench for the paged MMU: a behavioral model of the status
// registers and page tables predicts each result, and a scoreboard compares
// every popped result against the oldest prediction, field by field.
// -----------------------------------------------------------------------------
module tb_paged_mmu_translate_and_check;
    import mmu_pkg::*;

    localparam logic [15:0] ERR_BITS = 16'o160000;

    // Behavioral model of the MMU plus the queue of predicted results.
    class mmu_scoreboard;
        logic [15:0] par_tbl [64];
        logic [15:0] pdr_tbl [64];
        logic [15:0] sr0, sr2, sr3;
        t_out        pending [$];
        int          mismatches;

        function void clear();
            for (int i = 0; i < 64; i++) begin
                par_tbl[i] = '0;
                pdr_tbl[i] = '0;
            end
            sr0 = '0;
            sr2 = '0;
            sr3 = '0;
            pending.delete();
            mismatches = 0;
        endfunction

        function t_out translate(t_in it);
            t_out        r;
            logic [2:0]  apf, acf;
            logic [12:0] df;
            logic [6:0]  bn, plf;
            logic [5:0]  idx;
            logic [15:0] pdrv, parv, n;
            logic [17:0] adder;
            logic [21:0] mpa;
            logic        dspace, ed, ple, upd, set_a, set_w;
            logic        f_nr, f_ple, f_ro, f_pg, ab, tr;
            logic [1:0]  cm;
            cm = it.processor_mode;
            r = '0;
            upd = 0; set_a = 0; set_w = 0;
            f_nr = 0; f_ple = 0; f_ro = 0; f_pg = 0; ab = 0; tr = 0;
            if (it.is_fetch && !((sr0 & ERR_BITS) != 0 || cm == CM_SUPER))
                sr2 = it.virtual_address;
            if (!sr0[0]) begin
                r.physical_address = {6'd0, it.virtual_address};
                return r;
            end
            apf = it.virtual_address[15:13];
            df = it.virtual_address[12:0];
            bn = df[12:6];
            case (cm)
                CM_KERNEL: dspace = sr3[2];
                CM_SUPER:  dspace = sr3[1];
                CM_USER:   dspace = sr3[0];
                default:   dspace = 0;
            endcase
            idx = {(it.in_trap ? CM_KERNEL : cm), dspace && !it.is_fetch, apf};
            pdrv = pdr_tbl[idx] & PDR_RD_MASK;
            parv = par_tbl[idx] & PAR_RD_MASK;
            adder = ({2'd0, parv} << 6) + {5'd0, df};
            if (adder[17:13] == 5'h1f)
                mpa = IOPAGE_BASE | {6'd0, adder[15:0]};
            else
                mpa = {4'd0, adder};
            plf = pdrv[14:8];
            ed = pdrv[3];
            acf = pdrv[2:0];
            ple = ed ? (bn < plf) : (bn > plf);
            if (it.is_write) begin
                case (acf) inside
                    ACF_NONRES, ACF_RSVD3, ACF_RSVD7: begin
                        upd = 1; f_pg = 1; f_nr = 1; f_ple = ple; ab = 1;
                    end
                    ACF_RO_TRAP, ACF_RO: begin
                        upd = 1; f_pg = 1; f_ro = 1; f_ple = ple; ab = 1;
                    end
                    ACF_TRAP_RW: begin
                        upd = 1; set_a = 1; f_nr = 1; f_pg = 1; tr = 1;
                    end
                    ACF_RW: begin
                        upd = 1; f_pg = 1;
                        set_w = !it.wbit_inhibit && mpa != STATUS_ZERO_PHYS_ADDR;
                        if (ple) begin
                            f_ple = 1; tr = 1;
                        end
                    end
                    default: ;
                endcase
            end else begin
                case (acf) inside
                    ACF_NONRES, ACF_RSVD3, ACF_RSVD7: begin
                        f_nr = 1; f_pg = 1; f_ple = ple; ab = 1;
                    end
                    ACF_TRAP_RW: begin
                        upd = 1; set_a = 1; f_ple = ple; f_pg = 1; f_nr = 1; tr = 1;
                    end
                    ACF_RO, ACF_TRAP_WR, ACF_RW: begin
                        f_pg = 1;
                        if (ple) begin
                            f_ple = 1; ab = 1;
                        end
                    end
                    default: ;
                endcase
            end
            if (upd)
                pdr_tbl[idx] = pdrv | (set_a ? 16'o200 : 16'o0) | (set_w ? 16'o100 : 16'o0);
            if ((f_nr || f_ple || f_ro || f_pg) && (sr0 & ERR_BITS) == 0) begin
                n = sr0;
                n[15] = f_nr | sr0[15];
                n[14] = f_ple | sr0[14];
                n[13] = f_ro | sr0[13];
                if (f_pg) begin
                    n[6:5] = cm;
                    n[3:1] = apf;
                end
                sr0 = n;
            end
            if (ab)
                r.outcome = OC_ABORT;
            else if (tr)
                r.outcome = OC_TRAP;
            else
                r.physical_address = mpa;
            return r;
        endfunction

        function void note_input(t_in it);
            t_out        r;
            logic [5:0]  idx;
            logic [15:0] v;
            r = '0;
            idx = {it.table_select, it.io_offset[4:1]};
            case (it.mode)
                MODE_REG_RD:
                    case (it.reg_select)
                        REG_SR0: r.read_data = sr0;
                        REG_SR2: r.read_data = sr2;
                        REG_SR3: r.read_data = sr3;
                        default: r.read_data = '0;
                    endcase
                MODE_REG_WR:
                    if (it.reg_select == REG_SR0)
                        sr0 = it.byte_write ? {sr0[15:8], it.write_data[7:0]} : it.write_data;
                    else if (it.reg_select == REG_SR3)
                        sr3 = it.byte_write ? {sr3[15:8], it.write_data[7:0]} : it.write_data;
                MODE_TBL_RD:
                    r.read_data = it.io_offset[5] ? par_tbl[idx] & PAR_RD_MASK
                                                  : pdr_tbl[idx] & PDR_RD_MASK;
                MODE_TBL_WR: begin
                    v = it.io_offset[5] ? par_tbl[idx] : pdr_tbl[idx];
                    if (!it.byte_write)
                        v = it.write_data;
                    else if (it.io_offset[0])
                        v[15:8] = it.write_data[7:0];
                    else
                        v[7:0] = it.write_data[7:0];
                    if (it.io_offset[5])
                        par_tbl[idx] = v;
                    else
                        pdr_tbl[idx] = v & PDR_WR_MASK;
                end
                MODE_XLATE:
                    r = translate(it);
                MODE_RESET:
                    sr0 = sr0 & ~(ERR_BITS | 16'o400);
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.read_data !== want.read_data || got.outcome !== want.outcome ||
                got.physical_address !== want.physical_address) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp rd=%h pa=%h oc=%0d  got rd=%h pa=%h oc=%0d",
                             want.read_data, want.physical_address, want.outcome,
                             got.read_data, got.physical_address, got.outcome);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, push, full, empty, pop;
    t_in  i_item;
    t_out o_result;

    mmu_scoreboard sb;
    int  hold_cycles;   // long receiver hold-off requested by the stimulus
    bit  pop_enable;

    paged_mmu_translate_and_check uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_item(i_item), .empty(empty), .pop(pop), .o_result(o_result)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // scoreboard hookup: record accepted items and check popped results on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full)
            sb.note_input(i_item);
        if (i_rst_n && pop && !empty)
            sb.check_result(o_result);
    end

    // receiver: own stall pattern, plus a long hold-off on request
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                pop <= 1'b0;
            end else if (!pop_enable)
                pop <= 1'b0;
            else
                pop <= ($urandom_range(0, 9) < 7);
        end
    end

    task automatic send(t_in it);
        i_item <= it;
        push <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic go_idle(int n);
        push <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    function automatic t_in blank(logic [2:0] m);
        t_in it;
        it = '0;
        it.mode = m;
        return it;
    endfunction

    // random item, biased toward translations through a populated table
    function automatic t_in rand_item();
        t_in         it;
        int          sel;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        it = raw[$bits(t_in)-1:0];
        sel = $urandom_range(0, 99);
        if (sel < 50)
            it.mode = MODE_XLATE;
        else if (sel < 72)
            it.mode = MODE_TBL_WR;
        else if (sel < 82)
            it.mode = MODE_TBL_RD;
        else if (sel < 88)
            it.mode = MODE_REG_RD;
        else if (sel < 94)
            it.mode = MODE_REG_WR;
        else if (sel < 98)
            it.mode = MODE_RESET;
        else
            it.mode = 3'($urandom_range(6, 7));
        // keep the unit on most of the time
        if (it.mode == MODE_REG_WR && it.reg_select == REG_SR0 && $urandom_range(0, 3) != 0)
            it.write_data[0] = 1'b1;
        // keep error bits clear often so faults keep latching
        if (it.mode == MODE_REG_WR && it.reg_select == REG_SR0 && $urandom_range(0, 1) != 0)
            it.write_data[15:13] = 3'd0;
        return it;
    endfunction

    initial begin
        t_in it;
        int  sent, burst;
        sb = new();
        sb.clear();
        hold_cycles = 0;
        pop_enable = 1'b1;
        push = 1'b0;
        i_item = '0;
        i_rst_n = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: registers, table extremes, translation off and on
        send(blank(MODE_REG_RD));
        it = blank(MODE_XLATE); it.is_fetch = 1; it.virtual_address = 16'hffff;
        send(it);
        it = blank(MODE_REG_RD); it.reg_select = REG_SR2; send(it);
        it = blank(MODE_REG_WR); it.reg_select = REG_SR3; it.write_data = 16'hffff; send(it);
        it = blank(MODE_REG_WR); it.reg_select = REG_SR1; it.write_data = 16'hffff; send(it);
        it = blank(MODE_REG_WR); it.reg_select = REG_SR2; it.write_data = 16'h1234; send(it);
        it = blank(MODE_REG_RD); it.reg_select = REG_SR3; send(it);
        it = blank(MODE_TBL_WR); it.io_offset = 6'h3f; it.table_select = 2'd3;
        it.write_data = 16'hffff; send(it);
        it.mode = MODE_TBL_RD; send(it);
        it = blank(MODE_TBL_WR); it.io_offset = 6'h1e; it.table_select = 2'd3;
        it.write_data = 16'hffff; send(it);
        it.mode = MODE_TBL_RD; send(it);
        it = blank(MODE_TBL_WR); it.io_offset = 6'h21; it.byte_write = 1;
        it.write_data = 16'h00ab; send(it);
        it.mode = MODE_TBL_RD; send(it);
        // map kernel page 7 to the I/O page, write-enabled, full length
        it = blank(MODE_TBL_WR); it.io_offset = 6'h2e; it.write_data = 16'o7600; send(it);
        it = blank(MODE_TBL_WR); it.io_offset = 6'h0e; it.write_data = 16'o77406; send(it);
        it = blank(MODE_REG_WR); it.write_data = 16'd1; send(it);
        it = blank(MODE_REG_WR); it.reg_select = REG_SR3; it.byte_write = 1;
        it.write_data = 16'h0; send(it);
        // write hitting the status register 0 address leaves the written bit clear
        it = blank(MODE_XLATE); it.is_write = 1; it.virtual_address = 16'o177572; send(it);
        it.wbit_inhibit = 1; it.virtual_address = 16'o160000; send(it);
        it.wbit_inhibit = 0; send(it);
        it = blank(MODE_TBL_RD); it.io_offset = 6'h0e; send(it);
        it = blank(MODE_XLATE); it.virtual_address = 16'o020000; send(it);
        send(blank(MODE_REG_RD));
        send(blank(MODE_RESET));
        send(blank(MODE_NOP));

        // long receiver hold-off while items keep coming
        hold_cycles = 300;
        for (int i = 0; i < 20; i++) send(rand_item());
        drain();

        sent = 0;
        while (sent < 1420) begin
            burst = $urandom_range(1, 30);
            for (int i = 0; i < burst; i++) begin
                send(rand_item());
                sent++;
            end
            if ($urandom_range(0, 19) == 0)
                drain();
            else if ($urandom_range(0, 2) != 0)
                go_idle($urandom_range(1, 8));
        end
        drain();
        repeat (20) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
